/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the design. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* design/pre_pkg.sv */
// ----------------------------------------------------------------------------
// pre_pkg
// Types and constants shared by the reprojection error block.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam int ROT_W   = 20;
    localparam int QUO_W   = 41;
    localparam int DEN_W   = 53;
    localparam int DIV_LAT = QUO_W + 2;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 2;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_HIGH  = 5;

    localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

    typedef logic signed [53:0] t_coord;

    typedef enum logic [2:0] {
        CFG_ROT0, CFG_ROT1, CFG_ROT2, CFG_TRANS, CFG_FOCAL, CFG_PP
    } t_cfg_idx;

    typedef struct packed {
        t_coord      x;
        t_coord      y;
        t_coord      z;
        logic        depth_inv;
        logic [15:0] obs_u;
        logic [15:0] obs_v;
        logic        last;
    } t_cam;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] cx;
        logic [31:0] cy;
    } t_intr;

    typedef struct packed {
        logic        sign_u;
        logic        sign_v;
        logic [15:0] obs_u;
        logic [15:0] obs_v;
        logic        depth_inv;
        logic        last;
    } t_dsb;

    typedef struct packed {
        logic signed [31:0] pu;
        logic signed [31:0] pv;
        logic               depth_inv;
        logic               last;
    } t_ssb;

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > 43'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -43'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/pinhole_reprojection_error.sv */
// ----------------------------------------------------------------------------
// pinhole_reprojection_error
// Projects a world point through a rigid transform and pinhole intrinsics and
// reports the projected pixel and its distance to the observed pixel.
// ----------------------------------------------------------------------------
// One point is taken per clock while busy is low; a result beat appears on
// o_valid after the point has passed the 41-stage divider and the 32-stage
// square root of the back end. Results cannot be held off: o_valid is high
// for exactly one cycle per point, in input order. busy rises only if the
// internal queue holds five points, which steady streaming does not cause.
// The user writes registers through i_cfg_we / i_cfg_addr / i_cfg_data only
// while no point is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pinhole_reprojection_error (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    input  logic [15:0]        i_observed_u,
    input  logic [15:0]        i_observed_v,
    input  logic               i_last_point,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_projected_u,
    output logic signed [31:0] o_projected_v,
    output logic [31:0]        o_pixel_error,
    output logic               o_depth_invalid,
    output logic               o_last_result
);

    logic           push, nonempty, almost_full;
    pre_pkg::t_cam  item_in, item_out;
    pre_pkg::t_intr intr;

    assign busy = almost_full;

    pre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (start && !almost_full),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .i_observed_u (i_observed_u),
        .i_observed_v (i_observed_v),
        .i_last_point (i_last_point),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_item       (item_in),
        .o_intr       (intr)
    );

    pre_fifo u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_data        (item_in),
        .i_pop         (nonempty),
        .o_nonempty    (nonempty),
        .o_data        (item_out),
        .o_almost_full (almost_full)
    );

    pre_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (nonempty),
        .i_item          (item_out),
        .i_intr          (intr),
        .o_valid         (o_valid),
        .o_projected_u   (o_projected_u),
        .o_projected_v   (o_projected_v),
        .o_pixel_error   (o_pixel_error),
        .o_depth_invalid (o_depth_invalid),
        .o_last_result   (o_last_result)
    );

endmodule

/* design/pre_front.sv */
// ----------------------------------------------------------------------------
// pre_front
// Register file and rigid transform of the world point into the camera frame.
// ----------------------------------------------------------------------------
module pre_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic signed [31:0]  i_world_x,
    input  logic signed [31:0]  i_world_y,
    input  logic signed [31:0]  i_world_z,
    input  logic [15:0]         i_observed_u,
    input  logic [15:0]         i_observed_v,
    input  logic                i_last_point,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [63:0]         i_cfg_data,
    output logic                o_push,
    output pre_pkg::t_cam       o_item,
    output pre_pkg::t_intr      o_intr
);

    logic [59:0] r_rot0, r_rot1, r_rot2, r_trans;
    logic [63:0] r_focal, r_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot0  <= 60'h0_0000_0000_0004_0000;
            r_rot1  <= 60'h0_0000_0040_0000_0000;
            r_rot2  <= 60'h400_0000_0000_0000;
            r_trans <= '0;
            r_focal <= 64'h0001_0000_0001_0000;
            r_pp    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pre_pkg::CFG_ROT0:  r_rot0  <= i_cfg_data[59:0];
                pre_pkg::CFG_ROT1:  r_rot1  <= i_cfg_data[59:0];
                pre_pkg::CFG_ROT2:  r_rot2  <= i_cfg_data[59:0];
                pre_pkg::CFG_TRANS: r_trans <= i_cfg_data[59:0];
                pre_pkg::CFG_FOCAL: r_focal <= i_cfg_data;
                pre_pkg::CFG_PP:    r_pp    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_intr.fx = r_focal[31:0];
    assign o_intr.fy = r_focal[63:32];
    assign o_intr.cx = r_pp[31:0];
    assign o_intr.cy = r_pp[63:32];

    logic [59:0]        rot_row [3];
    logic signed [19:0] rot_e   [9];

    always_comb begin
        rot_row[0] = r_rot0;
        rot_row[1] = r_rot1;
        rot_row[2] = r_rot2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rot_e[i*3+j] = rot_row[i][pre_pkg::ROT_W*j +: pre_pkg::ROT_W];
            end
        end
    end

    // stage 0: capture the beat
    logic               r_f0_valid, r_f1_valid, r_f2_valid;
    logic signed [31:0] r_w [3];
    logic [15:0]        r_f0_u, r_f0_v, r_f1_u, r_f1_v;
    logic               r_f0_last, r_f1_last;
    logic signed [51:0] r_prod [9];
    pre_pkg::t_cam      r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f0_valid <= i_accept;
            r_f1_valid <= r_f0_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    pre_pkg::t_coord cam [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cam[i] = pre_pkg::t_coord'(r_prod[i*3]) + pre_pkg::t_coord'(r_prod[i*3+1])
                   + pre_pkg::t_coord'(r_prod[i*3+2])
                   + pre_pkg::t_coord'($signed({r_trans[pre_pkg::ROT_W*i +: pre_pkg::ROT_W],
                                                26'b0}));
        end
    end

    always_ff @(posedge i_clk) begin
        r_w[0]    <= i_world_x;
        r_w[1]    <= i_world_y;
        r_w[2]    <= i_world_z;
        r_f0_u    <= i_observed_u;
        r_f0_v    <= i_observed_v;
        r_f0_last <= i_last_point;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i*3+j] <= rot_e[i*3+j] * r_w[j];
            end
        end
        r_f1_u    <= r_f0_u;
        r_f1_v    <= r_f0_v;
        r_f1_last <= r_f0_last;
        r_item.x         <= cam[0];
        r_item.y         <= cam[1];
        r_item.z         <= cam[2];
        r_item.depth_inv <= (cam[2] <= 54'sd0);
        r_item.obs_u     <= r_f1_u;
        r_item.obs_v     <= r_f1_v;
        r_item.last      <= r_f1_last;
    end

    assign o_push = r_f2_valid;
    assign o_item = r_item;

endmodule

/* design/pre_fifo.sv */
// ----------------------------------------------------------------------------
// pre_fifo
// Short queue between the transform front end and the projection back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pre_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pre_pkg::t_cam i_data,
    input  logic          i_pop,
    output logic          o_nonempty,
    output pre_pkg::t_cam o_data,
    output logic          o_almost_full
);

    pre_pkg::t_cam r_mem [pre_pkg::FIFO_DEPTH];
    logic [2:0]    r_wptr, r_rptr;
    logic [3:0]    r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 4'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 3'd1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data        = r_mem[r_rptr];
    assign o_nonempty    = (r_count != 4'd0);
    assign o_almost_full = (r_count >= 4'(pre_pkg::FIFO_HIGH));

    `ASSERT_AT(a_no_overflow, i_clk, i_rst_n, (i_push && !i_pop) |-> (r_count != 4'(pre_pkg::FIFO_DEPTH)), "queue overflow")
    `ASSERT_AT(a_no_underflow, i_clk, i_rst_n, i_pop |-> (r_count != 4'd0), "queue underflow")

endmodule

/* design/pre_div.sv */
// ----------------------------------------------------------------------------
// pre_div
// Pipelined restoring divider, one quotient bit per stage, rounded and capped.
// ----------------------------------------------------------------------------
module pre_div (
    input  logic        i_clk,
    input  logic [84:0] i_num,
    input  logic [52:0] i_den,
    output logic [40:0] o_quot
);

    localparam int QW = pre_pkg::QUO_W;

    logic [52:0] r_rem [QW+1];
    logic [40:0] r_nlo [QW+1];
    logic [40:0] r_q   [QW+1];
    logic [52:0] r_den [QW+1];
    logic        r_ovf [QW+1];
    logic [40:0] r_quot;

    logic [53:0] cur [QW];
    logic        ge  [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            cur[k] = {r_rem[k], r_nlo[k][40]};
            ge[k]  = (cur[k] >= {1'b0, r_den[k]});
        end
    end

    logic        rup;
    logic [41:0] qr;

    always_comb begin
        rup = ({r_rem[QW], 1'b0} >= {1'b0, r_den[QW]});
        qr  = {1'b0, r_q[QW]} + {41'd0, rup};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {9'd0, i_num[84:41]};
        r_ovf[0] <= ({9'd0, i_num[84:41]} >= i_den);
        r_nlo[0] <= i_num[40:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        for (int k = 0; k < QW; k++) begin
            r_rem[k+1] <= ge[k] ? 53'(cur[k] - {1'b0, r_den[k]}) : cur[k][52:0];
            r_nlo[k+1] <= {r_nlo[k][39:0], 1'b0};
            r_q[k+1]   <= {r_q[k][39:0], ge[k]};
            r_den[k+1] <= r_den[k];
            r_ovf[k+1] <= r_ovf[k];
        end
        if (r_ovf[QW] || qr > {1'b0, pre_pkg::QUOT_CAP}) begin
            r_quot <= pre_pkg::QUOT_CAP;
        end else begin
            r_quot <= qr[40:0];
        end
    end

    assign o_quot = r_quot;

endmodule

/* design/pre_sqrt.sv */
// ----------------------------------------------------------------------------
// pre_sqrt
// Pipelined integer square root, one result bit per stage, rounded, saturated.
// ----------------------------------------------------------------------------
module pre_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int NS = pre_pkg::SQRT_STEPS;

    logic [33:0] r_rem  [NS+1];
    logic [31:0] r_root [NS+1];
    logic [63:0] r_rad  [NS+1];
    logic [31:0] r_out;

    logic [35:0] cur   [NS];
    logic [35:0] trial [NS];
    logic        ge    [NS];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            cur[k]   = {r_rem[k], r_rad[k][63:62]};
            trial[k] = {2'b00, r_root[k], 2'b01};
            ge[k]    = (cur[k] >= trial[k]);
        end
    end

    logic [32:0] rounded;

    always_comb begin
        rounded = {1'b0, r_root[NS]};
        if (r_rem[NS] > {2'b00, r_root[NS]}) begin
            rounded = {1'b0, r_root[NS]} + 33'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_rad[0]  <= i_rad;
        for (int k = 0; k < NS; k++) begin
            r_rem[k+1]  <= ge[k] ? 34'(cur[k] - trial[k]) : cur[k][33:0];
            r_root[k+1] <= {r_root[k][30:0], ge[k]};
            r_rad[k+1]  <= {r_rad[k][61:0], 2'b00};
        end
        r_out <= rounded[32] ? 32'hFFFF_FFFF : rounded[31:0];
    end

    assign o_root = r_out;

endmodule

/* design/pre_back.sv */
// ----------------------------------------------------------------------------
// pre_back
// Projection, principal point offset and Euclidean pixel error.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pre_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pre_pkg::t_cam      i_item,
    input  pre_pkg::t_intr     i_intr,
    output logic               o_valid,
    output logic signed [31:0] o_projected_u,
    output logic signed [31:0] o_projected_v,
    output logic [31:0]        o_pixel_error,
    output logic               o_depth_invalid,
    output logic               o_last_result
);

    // magnitudes
    logic [53:0]   neg_x, neg_y, abs_x, abs_y;
    logic          r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic [52:0]   r_b0_mu, r_b0_mv, r_b0_den, r_b1_den, r_b2_den;
    pre_pkg::t_dsb r_b0_sb, r_b1_sb, r_b2_sb;
    logic [58:0]   r_b1_lo_u, r_b1_lo_v;
    logic [57:0]   r_b1_hi_u, r_b1_hi_v;
    logic [84:0]   r_b2_num_u, r_b2_num_v;

    always_comb begin
        neg_x = -i_item.x;
        neg_y = -i_item.y;
        abs_x = i_item.x[53] ? neg_x : i_item.x;
        abs_y = i_item.y[53] ? neg_y : i_item.y;
    end

    always_ff @(posedge i_clk) begin
        r_b0_mu          <= abs_x[52:0];
        r_b0_mv          <= abs_y[52:0];
        r_b0_den         <= i_item.z[52:0];
        r_b0_sb.sign_u   <= i_item.x[53];
        r_b0_sb.sign_v   <= i_item.y[53];
        r_b0_sb.obs_u    <= i_item.obs_u;
        r_b0_sb.obs_v    <= i_item.obs_v;
        r_b0_sb.depth_inv <= i_item.depth_inv;
        r_b0_sb.last     <= i_item.last;

        r_b1_lo_u <= r_b0_mu[26:0] * i_intr.fx;
        r_b1_hi_u <= r_b0_mu[52:27] * i_intr.fx;
        r_b1_lo_v <= r_b0_mv[26:0] * i_intr.fy;
        r_b1_hi_v <= r_b0_mv[52:27] * i_intr.fy;
        r_b1_den  <= r_b0_den;
        r_b1_sb   <= r_b0_sb;

        r_b2_num_u <= {26'd0, r_b1_lo_u} + {r_b1_hi_u, 27'd0};
        r_b2_num_v <= {26'd0, r_b1_lo_v} + {r_b1_hi_v, 27'd0};
        r_b2_den   <= r_b1_den;
        r_b2_sb    <= r_b1_sb;
    end

    logic [40:0] quot_u, quot_v;

    pre_div u_div_u (
        .i_clk  (i_clk),
        .i_num  (r_b2_num_u),
        .i_den  (r_b2_den),
        .o_quot (quot_u)
    );

    pre_div u_div_v (
        .i_clk  (i_clk),
        .i_num  (r_b2_num_v),
        .i_den  (r_b2_den),
        .o_quot (quot_v)
    );

    pre_pkg::t_dsb r_dsb    [pre_pkg::DIV_LAT];
    logic          r_dvalid [pre_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_dsb[0] <= r_b2_sb;
        for (int k = 1; k < pre_pkg::DIV_LAT; k++) begin
            r_dsb[k] <= r_dsb[k-1];
        end
    end

    // offset by the principal point
    pre_pkg::t_dsb      dsb;
    logic signed [42:0] sq_u, sq_v, sum_u, sum_v;

    always_comb begin
        dsb   = r_dsb[pre_pkg::DIV_LAT-1];
        sq_u  = dsb.sign_u ? -$signed({2'b00, quot_u}) : $signed({2'b00, quot_u});
        sq_v  = dsb.sign_v ? -$signed({2'b00, quot_v}) : $signed({2'b00, quot_v});
        sum_u = sq_u + $signed({11'd0, i_intr.cx});
        sum_v = sq_v + $signed({11'd0, i_intr.cy});
    end

    logic signed [31:0] r_b3_pu, r_b3_pv, r_b4_pu, r_b4_pv, r_b5_pu, r_b5_pv;
    logic [15:0]        r_b3_ou, r_b3_ov;
    logic               r_b3_inv, r_b3_last, r_b4_inv, r_b4_last, r_b5_inv, r_b5_last;
    logic [31:0]        r_b4_mu, r_b4_mv;
    logic [63:0]        r_b5_su, r_b5_sv, r_b6_n;
    pre_pkg::t_ssb      r_b6_sb;

    logic signed [33:0] du, dv;
    logic [33:0]        adu, adv;

    always_comb begin
        du  = $signed({6'd0, r_b3_ou, 12'd0}) - 34'(r_b3_pu);
        dv  = $signed({6'd0, r_b3_ov, 12'd0}) - 34'(r_b3_pv);
        adu = du[33] ? -du : du;
        adv = dv[33] ? -dv : dv;
    end

    always_ff @(posedge i_clk) begin
        r_b3_pu   <= pre_pkg::sat32(sum_u);
        r_b3_pv   <= pre_pkg::sat32(sum_v);
        r_b3_ou   <= dsb.obs_u;
        r_b3_ov   <= dsb.obs_v;
        r_b3_inv  <= dsb.depth_inv;
        r_b3_last <= dsb.last;

        r_b4_mu   <= adu[31:0];
        r_b4_mv   <= adv[31:0];
        r_b4_pu   <= r_b3_pu;
        r_b4_pv   <= r_b3_pv;
        r_b4_inv  <= r_b3_inv;
        r_b4_last <= r_b3_last;

        r_b5_su   <= r_b4_mu * r_b4_mu;
        r_b5_sv   <= r_b4_mv * r_b4_mv;
        r_b5_pu   <= r_b4_pu;
        r_b5_pv   <= r_b4_pv;
        r_b5_inv  <= r_b4_inv;
        r_b5_last <= r_b4_last;

        r_b6_n              <= r_b5_su + r_b5_sv;
        r_b6_sb.pu          <= r_b5_pu;
        r_b6_sb.pv          <= r_b5_pv;
        r_b6_sb.depth_inv   <= r_b5_inv;
        r_b6_sb.last        <= r_b5_last;
    end

    logic [31:0] root;

    pre_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_b6_n),
        .o_root (root)
    );

    pre_pkg::t_ssb r_ssb    [pre_pkg::SQRT_LAT];
    logic          r_svalid [pre_pkg::SQRT_LAT];

    always_ff @(posedge i_clk) begin
        r_ssb[0] <= r_b6_sb;
        for (int k = 1; k < pre_pkg::SQRT_LAT; k++) begin
            r_ssb[k] <= r_ssb[k-1];
        end
    end

    // valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            for (int k = 0; k < pre_pkg::DIV_LAT; k++) begin
                r_dvalid[k] <= 1'b0;
            end
            for (int k = 0; k < pre_pkg::SQRT_LAT; k++) begin
                r_svalid[k] <= 1'b0;
            end
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_dvalid[0] <= r_v2;
            for (int k = 1; k < pre_pkg::DIV_LAT; k++) begin
                r_dvalid[k] <= r_dvalid[k-1];
            end
            r_v3 <= r_dvalid[pre_pkg::DIV_LAT-1];
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_svalid[0] <= r_v6;
            for (int k = 1; k < pre_pkg::SQRT_LAT; k++) begin
                r_svalid[k] <= r_svalid[k-1];
            end
        end
    end

    // result beat
    pre_pkg::t_ssb      ssb;
    logic               r_out_valid, r_out_inv, r_out_last;
    logic signed [31:0] r_out_pu, r_out_pv;
    logic [31:0]        r_out_err;

    assign ssb = r_ssb[pre_pkg::SQRT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_svalid[pre_pkg::SQRT_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inv  <= ssb.depth_inv;
        r_out_last <= ssb.last;
        if (ssb.depth_inv) begin
            r_out_pu  <= '0;
            r_out_pv  <= '0;
            r_out_err <= 32'hFFFF_FFFF;
        end else begin
            r_out_pu  <= ssb.pu;
            r_out_pv  <= ssb.pv;
            r_out_err <= root;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_projected_u   = r_out_pu;
    assign o_projected_v   = r_out_pv;
    assign o_pixel_error   = r_out_err;
    assign o_depth_invalid = r_out_inv;
    assign o_last_result   = r_out_last;

    `ASSERT_AT(a_invalid_beat, i_clk, i_rst_n, (r_out_valid && r_out_inv) |-> (r_out_err == 32'hFFFF_FFFF && r_out_pu == 32'sd0 && r_out_pv == 32'sd0), "invalid depth beat not forced")

endmodule
